@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge with a
// reset that disables the check through disable iff.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/vrct_pkg.sv @@
// ---------------------------------------------------------------------------
// Voxel reference count table package
// Sizes, types, register codes and small helpers shared by the block.
// ---------------------------------------------------------------------------
package vrct_pkg;

   localparam int MAX_X       = 32;
   localparam int MAX_Y       = 32;
   localparam int MAX_Z       = 32;
   localparam int COUNT_WIDTH = 16;

   localparam int STORE_DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int INDEX_W     = $clog2(STORE_DEPTH);
   localparam int COORD_W     = 11;
   localparam int CELLS_W     = 6;
   localparam int PLANE_W     = 2 * CELLS_W;
   localparam int LINEAR_W    = CELLS_W + PLANE_W + 1;
   localparam int NEW_COUNT_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [INDEX_W-1:0]      index_type;
   typedef logic [CELLS_W-1:0]      cells_type;
   typedef logic [PLANE_W-1:0]      plane_type;
   typedef logic [LINEAR_W-1:0]     linear_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [NEW_COUNT_W-1:0]  new_count_type;
   typedef logic [CSR_INDEX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0]   csr_data_type;

   localparam count_type COUNT_MAX = '1;

   localparam csr_index_type CSR_COUNT_ENABLE = 2'd0;
   localparam csr_index_type CSR_CELLS_X      = 2'd1;
   localparam csr_index_type CSR_CELLS_Y      = 2'd2;
   localparam csr_index_type CSR_CELLS_Z      = 2'd3;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam cells_type CELLS_RESET = 6'd32;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_READ,
      ST_UPDATE
   } state_type;

   // grid sizes above the store limit act as the limit
   function automatic cells_type limit_cells(cells_type v, int lim);
      if (int'(v) > lim) begin
         return CELLS_W'(lim);
      end
      return v;
   endfunction

   function automatic logic coord_in_range(coord_type c, cells_type cells);
      return !c[COORD_W-1] && (c[COORD_W-2:0] < (COORD_W-1)'(cells));
   endfunction

endpackage

@@ design/vrct_req_if.sv @@
// ---------------------------------------------------------------------------
// Voxel request channel
// Valid/ready channel carrying one add or remove command per beat.
// ---------------------------------------------------------------------------
interface vrct_req_if;
   import vrct_pkg::*;

   logic      valid;
   logic      ready;
   logic      cmd;
   coord_type cell_x;
   coord_type cell_y;
   coord_type cell_z;

   modport source (output valid, cmd, cell_x, cell_y, cell_z, input ready);
   modport sink   (input valid, cmd, cell_x, cell_y, cell_z, output ready);
endinterface

@@ design/vrct_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Voxel response channel
// Valid/ready channel carrying one result per beat.
// ---------------------------------------------------------------------------
interface vrct_rsp_if;
   import vrct_pkg::*;

   logic          valid;
   logic          ready;
   logic          forward;
   logic          in_bounds;
   new_count_type new_count;
   coord_type     out_x;
   coord_type     out_y;
   coord_type     out_z;

   modport source (output valid, forward, in_bounds, new_count, out_x, out_y, out_z,
                   input ready);
   modport sink   (input valid, forward, in_bounds, new_count, out_x, out_y, out_z,
                   output ready);
endinterface

@@ design/voxel_reference_count_table_top.sv @@
// ---------------------------------------------------------------------------
// Voxel reference count table
// Per-voxel saturating reference counts held in one synchronous RAM.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus takes one add/remove command per beat with signed voxel
//   coordinates; rsp_bus returns exactly one result per command, in order.
//   csr_we/csr_index/csr_data write the enable and grid size registers;
//   write them only while no command is in flight.
//   Each command passes index, read and update steps before its result
//   appears; the next command is not accepted until the previous one has
//   left its update step, so commands are handled one at a time.
//   A finished result sits in the output register; the next command is
//   accepted meanwhile, and it waits in its update step only if the
//   previous result has still not been taken.
//   After reset all 32768 RAM entries are swept to zero, one entry per
//   cycle; req_bus.ready stays low until the sweep ends, while register
//   writes are taken as usual.
// ---------------------------------------------------------------------------
module voxel_reference_count_table_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  vrct_pkg::csr_index_type csr_index,
   input  vrct_pkg::csr_data_type  csr_data,
   vrct_req_if.sink               req_bus,
   vrct_rsp_if.source             rsp_bus
);
   import vrct_pkg::*;

   state_type state_ff, state_in;

   logic      count_enable_ff;
   cells_type cells_x_ff, cells_y_ff, cells_z_ff;
   plane_type plane_ff;

   logic      cmd_ff;
   coord_type cell_x_ff, cell_y_ff, cell_z_ff;
   logic      inb_ff;
   index_type idx_ff;
   index_type clr_addr_ff;
   count_type rd_data_ff;

   count_type count_mem [STORE_DEPTH];

   logic          rsp_valid_ff;
   logic          forward_ff;
   logic          in_bounds_ff;
   new_count_type new_count_ff;
   coord_type     out_x_ff, out_y_ff, out_z_ff;

   logic       req_take;
   logic       clearing;
   logic       out_free;
   logic       update_go;
   logic       clear_last;
   logic       inb_calc;
   linear_type idx_calc;
   count_type  cnt_upd;
   logic       fwd_upd;
   logic       mem_we;
   index_type  mem_waddr;
   count_type  mem_wdata;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_enable_ff <= 1'b0;
         cells_x_ff      <= limit_cells(CELLS_RESET, MAX_X);
         cells_y_ff      <= limit_cells(CELLS_RESET, MAX_Y);
         cells_z_ff      <= limit_cells(CELLS_RESET, MAX_Z);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COUNT_ENABLE: count_enable_ff <= csr_data[0];
            CSR_CELLS_X:      cells_x_ff      <= limit_cells(csr_data, MAX_X);
            CSR_CELLS_Y:      cells_y_ff      <= limit_cells(csr_data, MAX_Y);
            CSR_CELLS_Z:      cells_z_ff      <= limit_cells(csr_data, MAX_Z);
         endcase
      end
   end

   // plane size is registered from the grid size registers, well before use
   always_ff @(posedge clock) begin
      plane_ff <= PLANE_W'(cells_y_ff) * PLANE_W'(cells_z_ff);
   end

   // ---------------- control ----------------
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign clear_last = (clr_addr_ff == INDEX_W'(STORE_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_bus.valid) state_in = ST_INDEX;
         ST_INDEX:  state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_take  = 1'b0;
      clearing  = 1'b0;
      update_go = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clearing  = 1'b1;
         ST_IDLE:   req_take  = 1'b1;
         ST_INDEX:  ;
         ST_READ:   ;
         ST_UPDATE: update_go = out_free;
         default:   ;
      endcase
   end

   assign req_bus.ready = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (req_take && req_bus.valid) begin
         cmd_ff    <= req_bus.cmd;
         cell_x_ff <= req_bus.cell_x;
         cell_y_ff <= req_bus.cell_y;
         cell_z_ff <= req_bus.cell_z;
      end
   end

   assign inb_calc = coord_in_range(cell_x_ff, cells_x_ff) &&
                     coord_in_range(cell_y_ff, cells_y_ff) &&
                     coord_in_range(cell_z_ff, cells_z_ff);

   // x-major linear address; only meaningful when in bounds
   assign idx_calc = LINEAR_W'(cell_x_ff[CELLS_W-1:0]) * LINEAR_W'(plane_ff) +
                     LINEAR_W'(cell_y_ff[CELLS_W-1:0]) * LINEAR_W'(cells_z_ff) +
                     LINEAR_W'(cell_z_ff[CELLS_W-1:0]);

   always_ff @(posedge clock) begin
      if (state_ff == ST_INDEX) begin
         inb_ff <= inb_calc;
         idx_ff <= idx_calc[INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= count_mem[idx_ff];
   end

   always_comb begin
      cnt_upd = rd_data_ff;
      fwd_upd = 1'b0;
      if (cmd_ff == CMD_ADD) begin
         fwd_upd = (rd_data_ff == '0);
         if (rd_data_ff != COUNT_MAX) begin
            cnt_upd = rd_data_ff + 1'b1;
         end
      end else if (rd_data_ff != '0) begin
         cnt_upd = rd_data_ff - 1'b1;
         fwd_upd = (rd_data_ff == COUNT_WIDTH'(1));
      end
   end

   assign mem_we    = clearing || (update_go && count_enable_ff && inb_ff);
   assign mem_waddr = clearing ? clr_addr_ff : idx_ff;
   assign mem_wdata = clearing ? '0 : cnt_upd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (update_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update_go) begin
         in_bounds_ff <= inb_ff;
         out_x_ff     <= cell_x_ff;
         out_y_ff     <= cell_y_ff;
         out_z_ff     <= cell_z_ff;
         priority if (!count_enable_ff) begin
            forward_ff   <= 1'b1;
            new_count_ff <= '0;
         end else if (inb_ff) begin
            forward_ff   <= fwd_upd;
            new_count_ff <= NEW_COUNT_W'(cnt_upd);
         end else begin
            forward_ff   <= 1'b0;
            new_count_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.forward   = forward_ff;
   assign rsp_bus.in_bounds = in_bounds_ff;
   assign rsp_bus.new_count = new_count_ff;
   assign rsp_bus.out_x     = out_x_ff;
   assign rsp_bus.out_y     = out_y_ff;
   assign rsp_bus.out_z     = out_z_ff;

endmodule

@@ design/vrct_checker.sv @@
// ---------------------------------------------------------------------------
// Voxel reference count table checker
// Port-level checks on result consistency and command pacing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vrct_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    csr_we,
   input vrct_pkg::csr_index_type csr_index,
   input vrct_pkg::csr_data_type  csr_data,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_forward,
   input logic                    rsp_in_bounds,
   input vrct_pkg::new_count_type rsp_new_count
);
   import vrct_pkg::*;

   logic enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_we && (csr_index == CSR_COUNT_ENABLE)) begin
         enable_ff <= csr_data[0];
      end
   end

   // a stalled result beat stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_forward, rsp_in_bounds, rsp_new_count}), "result changed while stalled")

   // one command at a time: no acceptance straight after another
   `ASSERT_NEXT(a_req_spacing, clock, reset, req_valid && req_ready, !req_ready, "back-to-back acceptance")

   `ASSERT_HOLDS(a_disabled_fwd, clock, reset, !(rsp_valid && !enable_ff) || (rsp_forward && (rsp_new_count == '0)), "disabled result not forwarded with zero count")

   `ASSERT_HOLDS(a_oob_zero, clock, reset, !(rsp_valid && !rsp_in_bounds) || (rsp_new_count == '0), "out-of-bounds result with nonzero count")

   // a forwarded counted voxel just rose from zero or fell to zero
   `ASSERT_HOLDS(a_fwd_edge, clock, reset, !(rsp_valid && enable_ff && rsp_in_bounds && rsp_forward) || (rsp_new_count == NEW_COUNT_W'(0)) || (rsp_new_count == NEW_COUNT_W'(1)), "forward with count other than zero or one")

endmodule

bind voxel_reference_count_table_top vrct_checker u_vrct_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_we        (csr_we),
   .csr_index     (csr_index),
   .csr_data      (csr_data),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_forward   (rsp_bus.forward),
   .rsp_in_bounds (rsp_bus.in_bounds),
   .rsp_new_count (rsp_bus.new_count)
);
